FILE: rtl/csrg_pkg.sv
// ----------------------------------------------------------------------------
// csrg_pkg
// shared types and constants of the circle stamp region grow block
// ----------------------------------------------------------------------------
package csrg_pkg;

  localparam logic [1:0] CMD_DRAW   = 2'd0;
  localparam logic [1:0] CMD_SEED   = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;

  // grid geometry, bounded by the 8-bit size registers and 7-bit coordinates
  localparam int unsigned MAX_WIDTH  = 128;
  localparam int unsigned MAX_HEIGHT = 128;

  localparam int unsigned FIELD_W  = 10;
  localparam int unsigned HEIGHT_W = 10;
  localparam logic [7:0]  MIN_SIDE = 8'd8;
  localparam logic [7:0]  SIDE_RESET = 8'd64;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 10'd1023;

  // midpoint circle error term constants
  localparam logic signed [11:0] D_INIT  = 12'sd3;
  localparam logic signed [11:0] D_INC_A = 12'sd6;
  localparam logic signed [11:0] D_INC_B = 12'sd10;

  // per-cycle grid access controls
  typedef struct packed {
    logic lab_we;
    logic hgt_we;
    logic rd_en;
  } grid_ctl_t;

endpackage

FILE: rtl/circle_stamp_region_grow_top.sv
// ----------------------------------------------------------------------------
// circle_stamp_region_grow_top
// label/height map with seed, read and midpoint circle 3x3 stamping
// ----------------------------------------------------------------------------
// draw: 8 points per octant step; a point off the map rows is skipped, else its column
//   is wrapped one map_width at a time and, if its label is zero, a 3x3 stamp is written
// one transaction at a time, set by the single grid memory port
// after reset a clearing pass writes every grid entry, during which no transaction
//   is accepted
module circle_stamp_region_grow_top #(
  parameter int unsigned LABEL_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [6:0]  pos_x_i,
  input  logic [6:0]  pos_y_i,
  input  logic [6:0]  radius_i,
  input  logic [9:0]  region_label_i,
  input  logic [9:0]  elevation_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  label_out_o,
  output logic [9:0]  height_out_o,
  output logic [9:0]  stamps_placed_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i
);
  import csrg_pkg::*;

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_POINT, S_WRAP, S_RD, S_CHK, S_STAMP, S_NEXT,
    S_SEED, S_RDTILE, S_RDCAP, S_OUT
  } state_e;

  state_e state_q;

  logic [7:0]  mw_q, mh_q;
  logic [AW-1:0] clr_q;
  logic [6:0]  cx_q, cy_q;
  logic [LABEL_BITS-1:0] lab_q;
  logic [HEIGHT_W-1:0]   ele_q;
  logic [7:0]  dx_q, dy_q;
  logic signed [11:0] d_q;
  logic [2:0]  oct_q;
  logic signed [9:0] wx_q;
  logic [7:0]  py_q;
  logic [1:0]  si_q, sj_q;
  logic [FIELD_W-1:0] cnt_q, rl_q, rh_q;
  logic        out_valid_q;
  logic [FIELD_W-1:0] lo_q, ho_q, st_q;

  grid_ctl_t ctl;
  logic [AW-1:0] addr;
  logic [LABEL_BITS-1:0] lab_wdata, lab_rdata;
  logic [HEIGHT_W-1:0]   hgt_wdata, hgt_rdata;

  // size saturation
  function automatic logic [7:0] clamp_side(logic [7:0] v, int unsigned hi);
    logic [7:0] r;
    if (v < MIN_SIDE) r = MIN_SIDE;
    else if (11'(v) > 11'(hi)) r = 8'(hi);
    else r = v;
    return r;
  endfunction

  // octant point
  logic [7:0] xmag, ymag;
  logic signed [9:0] px_s, py_s;
  always_comb begin
    xmag = (oct_q[0] ^ oct_q[1]) ? dy_q : dx_q;
    ymag = (oct_q[0] ^ oct_q[1]) ? dx_q : dy_q;
    px_s = oct_q[1] ? $signed({3'b0, cx_q}) + $signed({2'b0, xmag})
                    : $signed({3'b0, cx_q}) - $signed({2'b0, xmag});
    py_s = oct_q[2] ? $signed({3'b0, cy_q}) + $signed({2'b0, ymag})
                    : $signed({3'b0, cy_q}) - $signed({2'b0, ymag});
  end
  logic py_ok;
  assign py_ok = (py_s >= 0) && (py_s < $signed({2'b0, mh_q}));

  // stamp neighbours with wrap
  logic [7:0] x8, xm, xp, ym, yp, tx, ty;
  always_comb begin
    x8 = wx_q[7:0];
    xm = (x8 == 8'd0) ? mw_q - 8'd1 : x8 - 8'd1;
    xp = ({1'b0, x8} + 9'd1 >= {1'b0, mw_q}) ? 8'd0 : x8 + 8'd1;
    ym = (py_q == 8'd0) ? mh_q - 8'd1 : py_q - 8'd1;
    yp = ({1'b0, py_q} + 9'd1 >= {1'b0, mh_q}) ? 8'd0 : py_q + 8'd1;
    case (sj_q)
      2'd0:    tx = xm;
      2'd1:    tx = x8;
      default: tx = xp;
    endcase
    case (si_q)
      2'd0:    ty = ym;
      2'd1:    ty = py_q;
      default: ty = yp;
    endcase
  end

  // step update
  logic signed [11:0] d_n;
  logic [7:0] dx_n, dy_n;
  always_comb begin
    dx_n = dx_q + 8'd1;
    if (d_q < 0) begin
      d_n  = d_q + $signed({2'b0, dx_q, 2'b0}) + D_INC_A;
      dy_n = dy_q;
    end else begin
      d_n  = d_q + $signed({2'b0, dx_q, 2'b0}) - $signed({2'b0, dy_q, 2'b0}) + D_INC_B;
      dy_n = dy_q - 8'd1;
    end
  end

  logic [15:0] lab_in_ext, lab_rd_ext;
  assign lab_in_ext = 16'(region_label_i);
  assign lab_rd_ext = 16'(lab_rdata);

  logic on_map;
  assign on_map = ({1'b0, cx_q} < mw_q) && ({1'b0, cy_q} < mh_q);

  // grid port
  always_comb begin
    ctl = '0;
    lab_wdata = lab_q;
    hgt_wdata = ele_q;
    addr = AW'(ty) * AW'(MAX_WIDTH) + AW'(tx);
    case (state_q)
      S_CLEAR: begin
        ctl.lab_we = 1'b1;
        ctl.hgt_we = 1'b1;
        lab_wdata = '0;
        hgt_wdata = '0;
        addr = clr_q;
      end
      S_RD: begin
        ctl.rd_en = 1'b1;
        addr = AW'(py_q) * AW'(MAX_WIDTH) + AW'(x8);
      end
      S_STAMP: begin
        ctl.lab_we = 1'b1;
        ctl.hgt_we = 1'b1;
      end
      S_SEED: begin
        // a seed outside the map writes nothing
        ctl.lab_we = on_map;
        addr = AW'(cy_q) * AW'(MAX_WIDTH) + AW'(cx_q);
      end
      S_RDTILE: begin
        ctl.rd_en = 1'b1;
        addr = AW'(cy_q) * AW'(MAX_WIDTH) + AW'(cx_q);
      end
      default: ;
    endcase
  end

  csrg_grid_ram #(.DEPTH(DEPTH), .AW(AW), .LW(LABEL_BITS)) u_grid (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .addr_i      (addr),
    .lab_wdata_i (lab_wdata),
    .hgt_wdata_i (hgt_wdata),
    .lab_rdata_o (lab_rdata),
    .hgt_rdata_o (hgt_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      mw_q <= SIDE_RESET;
      mh_q <= SIDE_RESET;
      clr_q <= '0;
      cx_q <= '0; cy_q <= '0;
      lab_q <= '0; ele_q <= '0;
      dx_q <= '0; dy_q <= '0; d_q <= '0; oct_q <= '0;
      wx_q <= '0; py_q <= '0; si_q <= '0; sj_q <= '0;
      cnt_q <= '0; rl_q <= '0; rh_q <= '0;
      out_valid_q <= 1'b0;
      lo_q <= '0; ho_q <= '0; st_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MAP_WIDTH)  mw_q <= clamp_side(cfg_wdata_i, MAX_WIDTH);
        if (cfg_idx_i == CFG_MAP_HEIGHT) mh_q <= clamp_side(cfg_wdata_i, MAX_HEIGHT);
      end
      if (out_valid_q && !out_stall_i && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            cx_q  <= pos_x_i;
            cy_q  <= pos_y_i;
            lab_q <= lab_in_ext[LABEL_BITS-1:0];
            ele_q <= elevation_i;
            dx_q  <= '0;
            dy_q  <= {1'b0, radius_i};
            d_q   <= D_INIT - $signed({4'b0, radius_i, 1'b0});
            oct_q <= '0;
            cnt_q <= '0; rl_q <= '0; rh_q <= '0;
            case (cmd_i)
              CMD_DRAW: state_q <= (radius_i == 7'd0) ? S_OUT : S_POINT;
              CMD_SEED: state_q <= S_SEED;
              CMD_READ: state_q <= S_RDTILE;
              default:  state_q <= S_OUT;
            endcase
          end
        end
        S_POINT: begin
          if (py_ok) begin
            wx_q <= px_s;
            py_q <= py_s[7:0];
            state_q <= S_WRAP;
          end else begin
            state_q <= S_NEXT;
          end
        end
        S_WRAP: begin
          // column reduced one map width per cycle
          if (wx_q < 0) wx_q <= wx_q + $signed({2'b0, mw_q});
          else if (wx_q >= $signed({2'b0, mw_q})) wx_q <= wx_q - $signed({2'b0, mw_q});
          else state_q <= S_RD;
        end
        S_RD: state_q <= S_CHK;
        S_CHK: begin
          si_q <= '0;
          sj_q <= '0;
          state_q <= (lab_rdata == '0) ? S_STAMP : S_NEXT;
        end
        S_STAMP: begin
          if (sj_q == 2'd2) begin
            sj_q <= '0;
            si_q <= si_q + 2'd1;
            if (si_q == 2'd2) begin
              if (cnt_q != FIELD_MAX) cnt_q <= cnt_q + 10'd1;
              state_q <= S_NEXT;
            end
          end else begin
            sj_q <= sj_q + 2'd1;
          end
        end
        S_NEXT: begin
          oct_q <= oct_q + 3'd1;
          if (oct_q == 3'd7) begin
            d_q  <= d_n;
            dx_q <= dx_n;
            dy_q <= dy_n;
            state_q <= (dy_n >= dx_n) ? S_POINT : S_OUT;
          end else begin
            state_q <= S_POINT;
          end
        end
        S_SEED: state_q <= S_OUT;
        S_RDTILE: state_q <= S_RDCAP;
        S_RDCAP: begin
          if (on_map) begin
            rl_q <= lab_rd_ext[FIELD_W-1:0];
            rh_q <= hgt_rdata;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            lo_q <= rl_q;
            ho_q <= rh_q;
            st_q <= cnt_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign label_out_o     = lo_q;
  assign height_out_o    = ho_q;
  assign stamps_placed_o = st_q;

  a_out_from_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside final state");

  a_hgt_write_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.hgt_we |-> (state_q == S_STAMP || state_q == S_CLEAR))
    else $error("height write outside stamp or clear");

  a_side_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mw_q >= MIN_SIDE) && (11'(mw_q) <= 11'(MAX_WIDTH)) && (mh_q >= MIN_SIDE))
    else $error("map size out of range");

  a_wrapped_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (wx_q >= 0 && wx_q < $signed({2'b0, mw_q})))
    else $error("column not wrapped before check");

endmodule

FILE: rtl/csrg_grid_ram.sv
// ----------------------------------------------------------------------------
// csrg_grid_ram
// single-port label and height grids, registered read
// ----------------------------------------------------------------------------
module csrg_grid_ram #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = 14,
  parameter int unsigned LW    = 10
) (
  input  logic                     clk_i,
  input  csrg_pkg::grid_ctl_t      ctl_i,
  input  logic [AW-1:0]            addr_i,
  input  logic [LW-1:0]            lab_wdata_i,
  input  logic [csrg_pkg::HEIGHT_W-1:0] hgt_wdata_i,
  output logic [LW-1:0]            lab_rdata_o,
  output logic [csrg_pkg::HEIGHT_W-1:0] hgt_rdata_o
);
  import csrg_pkg::*;

  logic [LW-1:0]       lab_mem [DEPTH];
  logic [HEIGHT_W-1:0] hgt_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.lab_we) begin
      lab_mem[addr_i] <= lab_wdata_i;
    end
    if (ctl_i.hgt_we) begin
      hgt_mem[addr_i] <= hgt_wdata_i;
    end
    if (ctl_i.rd_en) begin
      lab_rdata_o <= lab_mem[addr_i];
      hgt_rdata_o <= hgt_mem[addr_i];
    end
  end

endmodule
